### src/ucrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrb_pkg
// Shared types and constants for the console ring buffer block.
// ----------------------------------------------------------------------------
package ucrb_pkg;

    // default ring depths
    localparam int RX_DEPTH_DEF = 64;
    localparam int TX_DEPTH_DEF = 64;

    // field widths
    localparam int OP_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 6;
    localparam int IN_W     = 8;   // slave tdata width
    localparam int OUT_W    = 32;  // master tdata width, 25 used bits
    localparam int OUT_USED = STATUS_W + BYTE_W + 3 + 2 * FILL_W;

    // characters that expand to a CR LF pair
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_RX_BYTE  = 3'd0,
        OP_TX_READY = 3'd1,
        OP_TX_END   = 3'd2,
        OP_PUT      = 3'd3,
        OP_GET      = 3'd4
    } t_opcode;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_RX_EMPTY = 2'd1,
        ST_TX_FULL  = 2'd2
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic accept;  // capture item, launch ring reads
        logic exec;    // apply the operation
        logic wr2;     // write the LF of a CR LF pair
        logic load;    // move the result into the output register
    } t_ctrl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic pair;    // a second transmit write follows this exec
    } t_dp_status;

endpackage

### src/ucrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrb_ctrl
// Sequencer: accepts one transaction, steps it through exec and the optional
// second write, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ucrb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  ucrb_pkg::t_dp_status  i_status,
    output ucrb_pkg::t_ctrl_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WR2  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // command decode
    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_s_axis_tvalid;
        o_cmd.exec   = (r_state == S_EXEC);
        o_cmd.wr2    = (r_state == S_WR2);
        o_cmd.load   = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_status.pair ? S_WR2 : S_DONE;
            end
            S_WR2: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (o_cmd.load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output slot occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### src/ucrb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrb_datapath
// Receive and transmit rings (memories with registered reads), their
// pointers, the transmitter flags, the result and the output register.
// ----------------------------------------------------------------------------
module ucrb_datapath #(
    parameter int RX_DEPTH = ucrb_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = ucrb_pkg::TX_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ucrb_pkg::t_ctrl_cmd           i_cmd,
    output ucrb_pkg::t_dp_status          o_status,
    input  logic [ucrb_pkg::OP_W-1:0]     i_op,
    input  logic [ucrb_pkg::BYTE_W-1:0]   i_byte,
    output logic [ucrb_pkg::OUT_W-1:0]    o_result
);

    localparam int RX_PW = $clog2(RX_DEPTH);
    localparam int TX_PW = $clog2(TX_DEPTH);
    localparam int RX_FW = (RX_PW + 1 > ucrb_pkg::FILL_W) ? RX_PW + 1 : ucrb_pkg::FILL_W;
    localparam int TX_FW = (TX_PW + 1 > ucrb_pkg::FILL_W) ? TX_PW + 1 : ucrb_pkg::FILL_W;
    localparam int PAD_W = ucrb_pkg::OUT_W - ucrb_pkg::OUT_USED;

    // ring storage
    logic [ucrb_pkg::BYTE_W-1:0] r_rx_mem [RX_DEPTH];
    logic [ucrb_pkg::BYTE_W-1:0] r_tx_mem [TX_DEPTH];
    logic [ucrb_pkg::BYTE_W-1:0] r_rx_rdata, r_tx_rdata;

    // control state
    logic [RX_PW-1:0] r_rx_wr, n_rx_wr, r_rx_rd, n_rx_rd;
    logic [TX_PW-1:0] r_tx_wr, n_tx_wr, r_tx_rd, n_tx_rd;
    logic             r_active, n_active, r_end_wait, n_end_wait;

    // captured item and result
    logic [ucrb_pkg::OP_W-1:0]     r_op;
    logic [ucrb_pkg::BYTE_W-1:0]   r_byte;
    logic [ucrb_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [ucrb_pkg::BYTE_W-1:0]   r_res_data, n_res_data;
    logic                          r_res_valid, n_res_valid;
    logic [ucrb_pkg::OUT_W-1:0]    r_out;

    // working signals
    logic [RX_FW-1:0]            rx_fill;
    logic [TX_FW-1:0]            tx_fill, tx_need;
    logic                        rx_empty, tx_empty, put_fits, is_pair, do_put;
    logic [ucrb_pkg::BYTE_W-1:0] put_ch, tx_wdata;
    logic                        tx_we, rx_we;
    logic [RX_PW-1:0]            rx_wr_inc, rx_rd_inc;
    logic [TX_PW-1:0]            tx_wr_inc, tx_rd_inc;

    // pointer increments with wrap
    always_comb begin
        rx_wr_inc = (r_rx_wr == RX_PW'(RX_DEPTH - 1)) ? '0 : r_rx_wr + RX_PW'(1);
        rx_rd_inc = (r_rx_rd == RX_PW'(RX_DEPTH - 1)) ? '0 : r_rx_rd + RX_PW'(1);
        tx_wr_inc = (r_tx_wr == TX_PW'(TX_DEPTH - 1)) ? '0 : r_tx_wr + TX_PW'(1);
        tx_rd_inc = (r_tx_rd == TX_PW'(TX_DEPTH - 1)) ? '0 : r_tx_rd + TX_PW'(1);
    end

    // fill levels
    always_comb begin
        rx_fill = (r_rx_wr >= r_rx_rd)
                ? RX_FW'(r_rx_wr) - RX_FW'(r_rx_rd)
                : RX_FW'(r_rx_wr) + RX_FW'(RX_DEPTH) - RX_FW'(r_rx_rd);
        tx_fill = (r_tx_wr >= r_tx_rd)
                ? TX_FW'(r_tx_wr) - TX_FW'(r_tx_rd)
                : TX_FW'(r_tx_wr) + TX_FW'(TX_DEPTH) - TX_FW'(r_tx_rd);
        rx_empty = (r_rx_wr == r_rx_rd);
        tx_empty = (r_tx_wr == r_tx_rd);
    end

    // put path: character, CR LF expansion, room check
    always_comb begin
        put_ch   = (r_op == ucrb_pkg::OP_GET) ? r_rx_rdata : r_byte;
        is_pair  = (put_ch == ucrb_pkg::CH_CR) || (put_ch == ucrb_pkg::CH_LF);
        tx_need  = is_pair ? TX_FW'(2) : TX_FW'(1);
        put_fits = (tx_fill + tx_need) < TX_FW'(TX_DEPTH);
        do_put   = (r_op == ucrb_pkg::OP_PUT) || ((r_op == ucrb_pkg::OP_GET) && !rx_empty);
        o_status.pair = i_cmd.exec && do_put && put_fits && is_pair;
    end

    // operation
    always_comb begin
        n_rx_wr      = r_rx_wr;
        n_rx_rd      = r_rx_rd;
        n_tx_wr      = r_tx_wr;
        n_tx_rd      = r_tx_rd;
        n_active     = r_active;
        n_end_wait   = r_end_wait;
        n_res_status = r_res_status;
        n_res_data   = r_res_data;
        n_res_valid  = r_res_valid;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        tx_wdata     = put_ch;
        if (i_cmd.exec) begin
            n_res_status = ucrb_pkg::ST_OK;
            n_res_data   = '0;
            n_res_valid  = 1'b0;
            case (r_op)
                ucrb_pkg::OP_RX_BYTE: begin
                    rx_we   = 1'b1;
                    n_rx_wr = rx_wr_inc;
                end
                ucrb_pkg::OP_TX_READY: begin
                    if (tx_empty) begin
                        n_end_wait = 1'b1;
                    end else begin
                        n_res_data  = r_tx_rdata;
                        n_res_valid = 1'b1;
                        n_tx_rd     = tx_rd_inc;
                    end
                end
                ucrb_pkg::OP_TX_END: begin
                    n_active   = 1'b0;
                    n_end_wait = 1'b0;
                end
                ucrb_pkg::OP_PUT, ucrb_pkg::OP_GET: begin
                    if ((r_op == ucrb_pkg::OP_GET) && rx_empty) begin
                        n_res_status = ucrb_pkg::ST_RX_EMPTY;
                    end else if (!put_fits) begin
                        n_res_status = ucrb_pkg::ST_TX_FULL;
                    end else begin
                        tx_we    = 1'b1;
                        tx_wdata = is_pair ? ucrb_pkg::CH_CR : put_ch;
                        n_tx_wr  = tx_wr_inc;
                        if (!r_active) begin
                            n_active   = 1'b1;
                            n_end_wait = 1'b0;
                        end
                        if (r_op == ucrb_pkg::OP_GET) begin
                            n_rx_rd    = rx_rd_inc;
                            n_res_data = put_ch;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.wr2) begin
            // second half of the CR LF pair
            tx_we    = 1'b1;
            tx_wdata = ucrb_pkg::CH_LF;
            n_tx_wr  = tx_wr_inc;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr    <= '0;
            r_rx_rd    <= '0;
            r_tx_wr    <= '0;
            r_tx_rd    <= '0;
            r_active   <= 1'b0;
            r_end_wait <= 1'b0;
        end else begin
            r_rx_wr    <= n_rx_wr;
            r_rx_rd    <= n_rx_rd;
            r_tx_wr    <= n_tx_wr;
            r_tx_rd    <= n_tx_rd;
            r_active   <= n_active;
            r_end_wait <= n_end_wait;
        end
    end

    // ring memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (rx_we) r_rx_mem[r_rx_wr] <= r_byte;
        if (tx_we) r_tx_mem[r_tx_wr] <= tx_wdata;
        if (i_cmd.accept) begin
            r_rx_rdata <= r_rx_mem[r_rx_rd];
            r_tx_rdata <= r_tx_mem[r_tx_rd];
        end
    end

    // item capture, result and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_byte <= i_byte;
        end
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
        r_res_valid  <= n_res_valid;
        if (i_cmd.load) begin
            r_out <= {{PAD_W{1'b0}},
                      tx_fill[ucrb_pkg::FILL_W-1:0],
                      rx_fill[ucrb_pkg::FILL_W-1:0],
                      r_end_wait, r_active, r_res_valid,
                      r_res_data, r_res_status};
        end
    end

    assign o_result = r_out;

endmodule

### src/uart_console_ring_buffers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_console_ring_buffers
// Console buffering for a serial port: receive and transmit rings with
// CR LF expansion on the transmit side and echo on get.
// ----------------------------------------------------------------------------
// Sequence: an accepted transaction steps through the accept with its ring
// read, the exec step, the second transmit write of the LF when a CR or LF
// is queued, and the load into the output register, which waits while the
// output register holds a result that is not being drained. A new
// transaction is accepted only after the previous result has been loaded.
// Reset: synchronous active low; pointers and flags clear, ring contents kept.
module uart_console_ring_buffers #(
    parameter int RX_DEPTH = ucrb_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = ucrb_pkg::TX_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [ucrb_pkg::IN_W-1:0]    i_s_axis_tdata,  // [7:0] data_byte
    input  logic [ucrb_pkg::OP_W-1:0]    i_s_axis_tuser,  // [2:0] opcode
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [1:0] status, [9:2] data_out, [10] line_byte_valid, [11] transmit_enable,
    // [12] end_wait, [18:13] rx_fill, [24:19] tx_fill, [31:25] zero
    output logic [ucrb_pkg::OUT_W-1:0]   o_m_axis_tdata
);

    ucrb_pkg::t_ctrl_cmd  cmd;
    ucrb_pkg::t_dp_status dp_status;

    ucrb_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_status        (dp_status),
        .o_cmd           (cmd)
    );

    ucrb_datapath #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (dp_status),
        .i_op     (i_s_axis_tuser),
        .i_byte   (i_s_axis_tdata[ucrb_pkg::BYTE_W-1:0]),
        .o_result (o_m_axis_tdata)
    );

    // one transaction in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("accepted a second transaction while one is in flight");

    // a result is only loaded into a free or draining output register
    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result overwrote a pending output");

    // a line byte is only reported with ok status
    a_line_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[10])
            |-> (o_m_axis_tdata[1:0] == ucrb_pkg::ST_OK))
        else $error("line byte reported with error status");

    // a rejected transaction returns no data
    a_reject_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[1:0] != ucrb_pkg::ST_OK))
            |-> (o_m_axis_tdata[9:2] == '0))
        else $error("rejected transaction returned data");

endmodule
